// ===== hw/rtl/oef_pkg.sv =====
`default_nettype none
package oef_pkg;
    localparam int FRAC_BITS = 8;
    localparam logic [33:0] SMOOTH_K = 34'd10430378350;
    localparam logic [31:0] RATE_SCALE = 32'd1000000;
    localparam logic [2:0] REG_MIN_CUTOFF = 3'd0;
    localparam logic [2:0] REG_BETA = 3'd1;
    localparam logic [2:0] REG_DERIV_CUTOFF = 3'd2;
    localparam logic [2:0] REG_SETTLE_TOL = 3'd3;
    localparam logic [2:0] REG_UNSETTLE_TOL = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RATE_MUL, ST_RATE_DIV, ST_DALPHA_MUL, ST_DALPHA_DIV, ST_DSMOOTH,
        ST_CUTOFF, ST_XALPHA_MUL, ST_XALPHA_DIV, ST_XSMOOTH, ST_COMMIT, ST_OUT
    } oef_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture input beat
        logic tare;       // tare op commit
        logic rate_mul;   // form (x - prev) * 1e6 and the elapsed time
        logic div_start;  // start the shared divider
        logic div_rate;   // divider operands: rate (1) or smoothing factor (0)
        logic dalpha_mul; // P = deriv cutoff * te
        logic dsmooth;    // smooth derivative from divider quotient
        logic cutoff;     // compute signal cutoff
        logic xalpha_mul; // P = signal cutoff * te
        logic xsmooth;    // smooth signal
        logic commit;     // update state
    } oef_cmd_t;

    typedef struct packed {
        logic div_done;
        logic is_tare;
    } oef_status_t;
endpackage
`default_nettype wire

// ===== hw/rtl/oef_divider.sv =====
`default_nettype none
module oef_divider
    import oef_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [63:0] divisor,
    output logic             done,
    output logic [63:0]      quotient
);
    // Restoring unsigned divider, one quotient bit per cycle.
    logic [63:0] quo_reg, quo_next;
    logic [64:0] rem_reg, rem_next;
    logic [63:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] shifted;
    logic [64:0] diff;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[63:0], quo_reg[63]};
        diff      = shifted - {1'b0, den_reg};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[64])
            begin
                rem_next = diff;
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/oef_datapath.sv =====
`default_nettype none
module oef_datapath
    import oef_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire oef_cmd_t    cmd,
    output oef_status_t      status,
    input  wire logic        op,
    input  wire logic signed [31:0] sample,
    input  wire logic [31:0] time_us,
    input  wire logic [23:0] min_cutoff_hz,
    input  wire logic [23:0] beta_gain,
    input  wire logic [23:0] deriv_cutoff_hz,
    input  wire logic [30:0] settle_tolerance,
    input  wire logic [30:0] unsettle_tolerance,
    output logic signed [31:0] reading,
    output logic signed [31:0] deriv,
    output logic             settled,
    output logic signed [31:0] last_settled,
    output logic [31:0]      settle_interval_us
);
    // Architectural state.
    logic signed [31:0] filt_reg, dprev_reg, tare_reg, capv_reg;
    logic [31:0] tprev_reg, capt_reg, capi_reg;
    logic        settled_reg;

    // Per-item working registers.
    logic        op_reg;
    logic signed [31:0] x_reg;
    logic [31:0] t_reg, te_reg;
    logic        rneg_reg;
    logic [63:0] rmag_reg;    // |x - prev| * 1e6
    logic [63:0] p_reg;       // cutoff * te
    logic signed [31:0] dx_reg, dhat_reg, xhat_reg;
    logic [31:0] dmag_reg;
    logic [31:0] cut_reg;
    logic        xp_pend_reg;

    logic [63:0] div_a, div_b, div_q;
    logic        div_done;

    oef_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    assign div_a = cmd.div_rate ? rmag_reg : {14'd0, SMOOTH_K, 16'd0};
    assign div_b = cmd.div_rate ? {32'd0, te_reg} : (p_reg + {30'd0, SMOOTH_K});

    assign status.div_done = div_done;
    assign status.is_tare  = op_reg;

    // Smoothing: (a*x + om*prev + 2^15) >> 16 with floor, om <= 65536.
    function automatic logic signed [31:0] smooth_f(input logic [63:0] om,
        input logic signed [31:0] x, input logic signed [31:0] prev);
        logic signed [17:0] om_s, a_s;
        logic signed [50:0] v;
        begin
            om_s = $signed({1'b0, om[16:0]});
            a_s  = 18'sd65536 - om_s;
            v = 51'(a_s * x) + 51'(om_s * prev) + 51'sd32768;
            smooth_f = v[47:16];
        end
    endfunction

    logic signed [32:0] diff33;
    logic [32:0] dabs;
    logic [31:0] te_raw;
    logic [63:0] rsat_q;
    logic signed [31:0] rate_sat;
    logic [55:0] bprod;
    logic [48:0] csum;
    logic signed [32:0] rd, ls;

    always_comb
    begin
        diff33 = 33'(x_reg) - 33'(filt_reg);
        dabs   = diff33[32] ? 33'(-diff33) : 33'(diff33);
        te_raw = t_reg - tprev_reg;
        rsat_q = div_q;
        if (rneg_reg)
            rate_sat = (rsat_q >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(rsat_q[31:0]);
        else
            rate_sat = (rsat_q >= 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(rsat_q[31:0]);
        bprod = beta_gain * dmag_reg;
        csum  = {25'd0, min_cutoff_hz} + 49'(bprod >> FRAC_BITS);
        rd = 33'(filt_reg) - 33'(tare_reg);
        ls = 33'(capv_reg) - 33'(tare_reg);
    end

    // p for the signal cutoff is loaded the cycle after cut_reg settles.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            xp_pend_reg <= 1'b0;
        else
            xp_pend_reg <= cmd.xalpha_mul;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= op;
            x_reg  <= sample;
            t_reg  <= time_us;
        end
        if (cmd.rate_mul)
        begin
            te_reg   <= (te_raw == 32'd0) ? 32'd1 : te_raw;
            rneg_reg <= diff33[32];
            rmag_reg <= 64'(dabs) * 64'(RATE_SCALE);
        end
        if (cmd.dalpha_mul)
        begin
            dx_reg <= rate_sat;
            p_reg  <= 64'(deriv_cutoff_hz) * 64'(te_reg);
        end
        else if (xp_pend_reg)
            p_reg <= 64'(cut_reg) * 64'(te_reg);
        if (cmd.dsmooth)
            dhat_reg <= smooth_f(div_q, dx_reg, dprev_reg);
        if (cmd.cutoff)
            dmag_reg <= dhat_reg[31] ? 32'(-dhat_reg) : 32'(dhat_reg);
        if (cmd.xalpha_mul)
        begin
            cut_reg <= (csum > 49'h7FFF_FFFF) ? 32'h7FFF_FFFF : csum[31:0];
        end
        if (cmd.xsmooth)
            xhat_reg <= smooth_f(div_q, x_reg, filt_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg    <= '0;
            dprev_reg   <= '0;
            tprev_reg   <= '0;
            tare_reg    <= '0;
            settled_reg <= 1'b0;
            capv_reg    <= '0;
            capt_reg    <= '0;
            capi_reg    <= '0;
        end
        else if (cmd.tare)
            tare_reg <= filt_reg;
        else if (cmd.commit)
        begin
            if (dmag_reg < {1'b0, settle_tolerance})
                settled_reg <= 1'b1;
            else
            begin
                if (settled_reg)
                begin
                    capv_reg <= filt_reg;
                    capi_reg <= t_reg - capt_reg;
                    capt_reg <= t_reg;
                end
                if (dmag_reg > {1'b0, unsettle_tolerance})
                    settled_reg <= 1'b0;
            end
            filt_reg  <= xhat_reg;
            dprev_reg <= dhat_reg;
            tprev_reg <= t_reg;
        end
    end

    assign reading = (rd > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                     (rd < -33'sh0_8000_0000) ? 32'sh8000_0000 : rd[31:0];
    assign last_settled = (ls > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                          (ls < -33'sh0_8000_0000) ? 32'sh8000_0000 : ls[31:0];
    assign deriv = dprev_reg;
    assign settled = settled_reg;
    assign settle_interval_us = capi_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/oef_ctrl.sv =====
`default_nettype none
module oef_ctrl
    import oef_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  wire logic        out_stall,
    input  wire oef_status_t status,
    output oef_cmd_t         cmd
);
    oef_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RATE_MUL;
                end
            end
            ST_RATE_MUL:
            begin
                if (status.is_tare)
                begin
                    cmd.tare   = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.rate_mul = 1'b1;
                    state_next   = ST_RATE_DIV;
                end
            end
            ST_RATE_DIV:
            begin
                cmd.div_rate  = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = ST_DALPHA_MUL;
            end
            ST_DALPHA_MUL:
            begin
                if (status.div_done)
                begin
                    cmd.dalpha_mul = 1'b1;
                    state_next     = ST_DALPHA_DIV;
                end
            end
            ST_DALPHA_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DSMOOTH;
            end
            ST_DSMOOTH:
            begin
                if (status.div_done)
                begin
                    cmd.dsmooth = 1'b1;
                    state_next  = ST_CUTOFF;
                end
            end
            ST_CUTOFF:
            begin
                cmd.cutoff = 1'b1;
                state_next = ST_XALPHA_MUL;
            end
            ST_XALPHA_MUL:
            begin
                cmd.xalpha_mul = 1'b1;
                state_next     = ST_XALPHA_DIV;
            end
            ST_XALPHA_DIV:
            begin
                // p_reg is loaded at the end of this cycle; start next cycle.
                state_next = ST_XSMOOTH;
            end
            ST_XSMOOTH:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (status.div_done)
                begin
                    cmd.xsmooth = 1'b1;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== hw/rtl/one_euro_filter_settle_detect.sv =====
// Channel | Beat fields                              | Handshake
// input   | op, sample, time_us                      | in_valid / in_stall
// output  | reading, deriv, settled, last_settled,   | out_valid / out_stall
//         | settle_interval_us                       |
// config  | APB, registers at 4*i                    | psel/penable/pwrite
//
// A sample beat makes three passes through the shared 64-bit restoring divider
// (rate, derivative factor, signal factor), with single-step states between
// them; a tare beat skips the divider and goes straight to the result.
// Reset is asynchronous and active low and clears all filter state and
// restores the register defaults. A result beat is held stable while
// out_stall is high; no new input beat is taken until it is delivered.
`default_nettype none
module one_euro_filter_settle_detect
    import oef_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic signed [31:0] sample,
    input  wire logic [31:0] time_us,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic signed [31:0] reading,
    output logic signed [31:0] deriv,
    output logic             settled,
    output logic signed [31:0] last_settled,
    output logic [31:0]      settle_interval_us,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [23:0] min_cut_reg, beta_reg, dcut_reg;
    logic [30:0] stol_reg, utol_reg;
    logic [2:0]  ridx;
    logic        wr;

    assign pready = 1'b1;
    assign ridx   = paddr[4:2];
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_cut_reg <= 24'd65536;
            beta_reg    <= 24'd0;
            dcut_reg    <= 24'd65536;
            stol_reg    <= 31'd256;
            utol_reg    <= 31'd512;
        end
        else if (wr)
        begin
            case (ridx)
                REG_MIN_CUTOFF:   min_cut_reg <= pwdata[23:0];
                REG_BETA:         beta_reg    <= pwdata[23:0];
                REG_DERIV_CUTOFF: dcut_reg    <= pwdata[23:0];
                REG_SETTLE_TOL:   stol_reg    <= pwdata[30:0];
                REG_UNSETTLE_TOL: utol_reg    <= pwdata[30:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            REG_MIN_CUTOFF:   prdata = {8'd0, min_cut_reg};
            REG_BETA:         prdata = {8'd0, beta_reg};
            REG_DERIV_CUTOFF: prdata = {8'd0, dcut_reg};
            REG_SETTLE_TOL:   prdata = {1'b0, stol_reg};
            REG_UNSETTLE_TOL: prdata = {1'b0, utol_reg};
            default:          prdata = 32'd0;
        endcase
    end

    oef_cmd_t    cmd, cmd_c;
    oef_status_t status;
    logic        out_valid_c;
    logic        commit_reg, wait_reg;

    oef_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid_c),
        .out_stall (out_stall || wait_reg || commit_reg),
        .status    (status),
        .cmd       (cmd_c)
    );

    // The state commit comes in the cycle after the signal smoothing step; the
    // result beat is held back until the committed state is visible.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            commit_reg <= 1'b0;
            wait_reg   <= 1'b0;
        end
        else
        begin
            commit_reg <= cmd_c.xsmooth;
            wait_reg   <= cmd_c.xsmooth;
        end
    end

    always_comb
    begin
        cmd        = cmd_c;
        cmd.commit = commit_reg;
    end

    assign out_valid = out_valid_c && !wait_reg && !commit_reg;

    oef_datapath u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .op                 (op),
        .sample             (sample),
        .time_us            (time_us),
        .min_cutoff_hz      (min_cut_reg),
        .beta_gain          (beta_reg),
        .deriv_cutoff_hz    (dcut_reg),
        .settle_tolerance   (stol_reg),
        .unsettle_tolerance (utol_reg),
        .reading            (reading),
        .deriv              (deriv),
        .settled            (settled),
        .last_settled       (last_settled),
        .settle_interval_us (settle_interval_us)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/oef_checker.sv =====
`default_nettype none
module oef_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] reading,
    input wire logic        pready
);
    // An accepted input beat is not followed by a result in the next cycle.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid)
        else $error("result too early");
    // No input is taken while a result is pending.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");
    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(reading))
        else $error("stalled result changed");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");
endmodule

bind one_euro_filter_settle_detect oef_checker u_oef_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .reading   (reading),
    .pready    (pready)
);
`default_nettype wire
